// File: design/frsq_pkg.sv
// frsq_pkg: shared types, constants and the fixed-point rounding helper
// for the fp32 reciprocal square root pipeline. No dependencies.
`default_nettype none
package frsq_pkg;

	localparam int unsigned NEWTON_STEPS_DEF = 6;

	localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
	localparam logic [31:0] THREE_HALF = 32'h00C0_0000;
	localparam logic [31:0] POS_INF    = 32'h7F80_0000;
	localparam logic [31:0] NAN_WORD   = 32'h7F80_0001;
	localparam logic [31:0] NEG_NAN    = 32'hFF80_0001;
	localparam logic [9:0]  EXP_BIAS   = 10'd127;

	// rounding bias 0x01437000 split at bit 23
	localparam logic [22:0] BIAS_FRAC  = 23'h43_7000;
	localparam logic [31:0] BIAS_INT   = 32'd2;

	typedef struct packed {
		logic               special;
		logic [31:0]        spec_word;
		logic               lb;
		logic signed [9:0]  k;
		logic [22:0]        halfm;
	} frsq_ctl_t;

	// (p + bias when low 23 bits nonzero) >> 23, kept to 32 bits
	function automatic logic [31:0] fix_round(input logic [63:0] p);
		logic        sticky;
		logic [23:0] low_sum;
		logic [31:0] inc;
		sticky  = |p[22:0];
		low_sum = {1'b0, p[22:0]} + {1'b0, BIAS_FRAC};
		inc     = sticky ? (BIAS_INT + {31'd0, low_sum[23]}) : 32'd0;
		return p[54:23] + inc;
	endfunction

endpackage
`default_nettype wire

// File: design/frsq_decode.sv
// frsq_decode: one register stage that sorts out special operands and sets
// up exponent, halved mantissa and the initial estimate. Uses frsq_pkg.
`default_nettype none
module frsq_decode (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [31:0]         operand_bits,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output frsq_pkg::frsq_ctl_t      out_ctl,
	output logic [31:0]              out_z
);
	import frsq_pkg::*;

	logic              v_s1;
	frsq_ctl_t         ctl_s1;
	logic [31:0]       z_s1;
	logic              en;
	frsq_ctl_t         ctl_d;
	logic [31:0]       z_d;
	logic [7:0]        expo;
	logic signed [9:0] e;
	logic signed [9:0] e_even;

	assign en       = !v_s1 || !out_stall;
	assign in_stall = !en;

	always_comb begin
		expo          = operand_bits[30:23];
		ctl_d.special = 1'b1;
		ctl_d.spec_word = 32'd0;
		if (operand_bits == POS_INF) begin
			ctl_d.spec_word = 32'd0;
		end else if (operand_bits[30:0] > POS_INF[30:0]) begin
			ctl_d.spec_word = {operand_bits[31], NAN_WORD[30:0]};
		end else if (expo == 8'd0) begin
			ctl_d.spec_word = {operand_bits[31], POS_INF[30:0]};
		end else if (operand_bits[31]) begin
			ctl_d.spec_word = NEG_NAN;
		end else begin
			ctl_d.special = 1'b0;
		end
		ctl_d.lb = ~expo[0];
		e        = $signed({2'b00, expo}) - $signed(EXP_BIAS);
		e_even   = e - $signed({9'd0, ctl_d.lb});
		ctl_d.k  = -(e_even >>> 1);
		ctl_d.halfm = ctl_d.lb ? {2'b01, operand_bits[22:2]} : {1'b1, operand_bits[22:1]};
		z_d      = ctl_d.lb ? (HIDDEN_BIT >> 1) : HIDDEN_BIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctl_s1 <= ctl_d;
			z_s1   <= z_d;
		end
	end

	assign out_valid = v_s1;
	assign out_ctl   = ctl_s1;
	assign out_z     = z_s1;

endmodule
`default_nettype wire

// File: design/frsq_step.sv
// frsq_step: one Newton step z * (1.5 - halfm * z * z) as three register
// stages, one multiplier each. Uses frsq_pkg (ctl type, fix_round).
`default_nettype none
module frsq_step (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire frsq_pkg::frsq_ctl_t in_ctl,
	input  wire logic [31:0]         in_z,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output frsq_pkg::frsq_ctl_t      out_ctl,
	output logic [31:0]              out_z
);
	import frsq_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        en1, en2, en3;
	frsq_ctl_t   ctl_s1, ctl_s2, ctl_s3;
	logic [31:0] z_s1, z_s2;
	logic [63:0] pzz_s1, phz_s2, pzc_s3;
	logic [31:0] zsq;
	logic [31:0] corr;

	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	assign zsq  = fix_round(pzz_s1);
	assign corr = THREE_HALF - fix_round(phz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ctl_s1 <= in_ctl;
			z_s1   <= in_z;
			pzz_s1 <= {32'd0, in_z} * {32'd0, in_z};
		end
		if (en2 && v_s1) begin
			ctl_s2 <= ctl_s1;
			z_s2   <= z_s1;
			phz_s2 <= {41'd0, ctl_s1.halfm} * {32'd0, zsq};
		end
		if (en3 && v_s2) begin
			ctl_s3 <= ctl_s2;
			pzc_s3 <= {32'd0, z_s2} * {32'd0, corr};
		end
	end

	assign out_valid = v_s3;
	assign out_ctl   = ctl_s3;
	assign out_z     = fix_round(pzc_s3);

endmodule
`default_nettype wire

// File: design/frsq_norm.sv
// frsq_norm: leading-zero count, renormalize and repack the estimate, or
// pass a special word; two stages, the second is the output register.
// Uses frsq_pkg.
`default_nettype none
module frsq_norm (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire frsq_pkg::frsq_ctl_t in_ctl,
	input  wire logic [31:0]         in_z,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [31:0]              result_bits
);
	import frsq_pkg::*;

	logic              v_s1, v_s2;
	logic              en1, en2;
	frsq_ctl_t         ctl_s1;
	logic [31:0]       z_s1;
	logic [5:0]        lz_s1;
	logic [31:0]       res_s2;
	logic [5:0]        lz;
	logic [31:0]       scan;
	logic signed [6:0] shift;
	logic [6:0]        rshift;
	logic [31:0]       zs;
	logic [31:0]       zf;
	logic signed [9:0] k_new;
	logic [9:0]        expw;
	logic [31:0]       res_d;

	assign en2      = !v_s2 || !out_stall;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_comb begin
		lz   = 6'd0;
		scan = in_z;
		if (scan[31:16] == 16'd0) begin lz = lz + 6'd16; scan = scan << 16; end
		if (scan[31:24] == 8'd0)  begin lz = lz + 6'd8;  scan = scan << 8;  end
		if (scan[31:28] == 4'd0)  begin lz = lz + 6'd4;  scan = scan << 4;  end
		if (scan[31:30] == 2'd0)  begin lz = lz + 6'd2;  scan = scan << 2;  end
		if (scan[31] == 1'b0)     begin lz = lz + 6'd1;  scan = scan << 1;  end
		if (scan[31] == 1'b0)     begin lz = lz + 6'd1;                     end
	end

	always_comb begin
		shift  = $signed({1'b0, lz_s1}) - 7'sd8 + $signed({6'd0, ctl_s1.lb});
		rshift = 7'(-shift);
		if (shift < 7'sd1) begin
			zs = z_s1 >> rshift[3:0];
		end else begin
			zs = z_s1 << shift[4:0];
		end
		k_new = ctl_s1.k - 10'(shift);
		zf    = zs >> ctl_s1.lb;
		expw  = 10'(k_new) + EXP_BIAS;
		res_d = ctl_s1.special ? ctl_s1.spec_word : {expw[8:0], zf[22:2], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ctl_s1 <= in_ctl;
			z_s1   <= in_z;
			lz_s1  <= lz;
		end
		if (en2 && v_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid   = v_s2;
	assign result_bits = res_s2;

endmodule
`default_nettype wire

// File: design/fp32_reciprocal_sqrt_newton.sv
// fp32_reciprocal_sqrt_newton: top level of the fp32 reciprocal square root
// pipeline. Instantiates frsq_decode, NEWTON_STEPS x frsq_step, frsq_norm.
//
// Usage:
//   Input channel in_valid / in_stall / operand_bits carries one fp32 word
//   per transaction; output channel out_valid / out_stall / result_bits
//   carries its reciprocal square root. A transaction completes on a rising
//   clk edge with valid high and stall low.
//   Stages: one decode stage, three multiplier stages per Newton step (six
//   steps by default, one 32x32 multiply each) and two normalize/pack
//   stages, the last being the output register. Throughput is one
//   transaction per cycle while out_stall is low.
//   Special operands (infinity, NaN, zero, denormal, negative) bypass the
//   arithmetic as a flag travelling with the data; latency is unchanged.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles close up while out_stall is high; in_stall rises only once every
//   stage holds a transaction. Nothing is dropped or repeated.
//   arst_n low clears all valid bits at once; the pipeline is empty and
//   ready in the first cycle after release. No state carries between items.
`default_nettype none
module fp32_reciprocal_sqrt_newton #(
	parameter int unsigned NEWTON_STEPS = frsq_pkg::NEWTON_STEPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] operand_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result_bits
);
	import frsq_pkg::*;

	logic [NEWTON_STEPS:0] stp_valid;
	logic [NEWTON_STEPS:0] stp_stall;
	frsq_ctl_t             stp_ctl [NEWTON_STEPS+1];
	logic [31:0]           stp_z   [NEWTON_STEPS+1];

	frsq_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operand_bits (operand_bits),
		.out_valid    (stp_valid[0]),
		.out_stall    (stp_stall[0]),
		.out_ctl      (stp_ctl[0]),
		.out_z        (stp_z[0])
	);

	for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_step
		frsq_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stp_valid[g]),
			.in_stall  (stp_stall[g]),
			.in_ctl    (stp_ctl[g]),
			.in_z      (stp_z[g]),
			.out_valid (stp_valid[g+1]),
			.out_stall (stp_stall[g+1]),
			.out_ctl   (stp_ctl[g+1]),
			.out_z     (stp_z[g+1])
		);
	end

	frsq_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (stp_valid[NEWTON_STEPS]),
		.in_stall    (stp_stall[NEWTON_STEPS]),
		.in_ctl      (stp_ctl[NEWTON_STEPS]),
		.in_z        (stp_z[NEWTON_STEPS]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_bits (result_bits)
	);

endmodule
`default_nettype wire

// File: design/frsq_checker.sv
// frsq_checker: port-level assertions for fp32_reciprocal_sqrt_newton,
// attached by bind. No package dependency.
`default_nettype none
module frsq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [31:0] operand_bits,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] result_bits
);

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_bits))
		else $error("output transaction changed while stalled");

	// computed results have bits 1..0 cleared; only NaN words carry bit 0
	a_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_bits[1:0] != 2'b00) |-> result_bits[30:0] == 31'h7F80_0001)
		else $error("low result bits set on a non-NaN result");

	// input backpressure only when the output is full and stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the output is free");

endmodule

bind fp32_reciprocal_sqrt_newton frsq_checker u_frsq_checker (.*);
`default_nettype wire
